// File: src/glyph_stripe_rle_decoder_macros.svh
// Assertion helpers for the checker file of the glyph decoder.
`ifndef GLYPH_STRIPE_RLE_DECODER_MACROS_SVH
`define GLYPH_STRIPE_RLE_DECODER_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define GSRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is held.
`define GSRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gsrd_pkg.sv
package gsrd_pkg;

    localparam int MAX_WIDTH   = 16;
    localparam int MAX_STRIPES = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int COL_W     = 5;
    localparam int STRIPE_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int CODING_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Field positions inside the slave-side tdata.
    localparam int F_WIDTH_LSB  = 0;
    localparam int F_LEFT_LSB   = 5;
    localparam int F_RIGHT_LSB  = 10;
    localparam int F_FIRST_LSB  = 15;
    localparam int F_END_LSB    = 18;
    localparam int F_CODING_LSB = 21;
    localparam int F_BYTE_LSB   = 23;

    localparam logic [BYTE_W-1:0] RUN_MASK_NIBBLE = 8'h0f;
    localparam logic [BYTE_W-1:0] RUN_MASK_PAIR   = 8'h03;
    localparam int RUN_SHIFT_NIBBLE = 4;
    localparam int RUN_SHIFT_PAIR   = 2;
    localparam logic [BYTE_W-1:0] BLANK_PIXELS    = 8'h00;

    typedef enum logic {
        CMD_HEADER = 1'b0,
        CMD_DATA   = 1'b1
    } t_cmd_kind;

    typedef enum logic [CODING_W-1:0] {
        COD_RAW    = 2'd0,
        COD_NIBBLE = 2'd1,
        COD_PAIR   = 2'd2
    } t_coding;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ADV
    } t_state;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [COL_W-1:0]      width;
        logic [COL_W-1:0]      left;
        logic [COL_W-1:0]      right;
        logic [STRIPE_W-1:0]   first_stripe;
        logic [STRIPE_W-1:0]   end_stripe;
        t_coding               coding;
        logic [BYTE_W-1:0]     data;
    } t_cmd;

    // Packed so that stripe lands in the lowest bits of the master tdata.
    typedef struct packed {
        logic              overrun;
        logic              glyph_done;
        logic              stripe_start;
        logic [BYTE_W-1:0] pixels;
        logic [3:0]        column;
        logic [1:0]        stripe;
    } t_col;

endpackage

// File: src/gsrd_front.sv
module gsrd_front
    import gsrd_pkg::*;
(
    input  logic                 i_valid,
    input  logic [S_TDATA_W-1:0] i_data,
    input  logic                 i_kind,
    input  logic                 i_queue_full,
    output logic                 o_ready,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [COL_W-1:0]    w_width_raw;
    logic [CODING_W-1:0] w_coding_raw;
    t_coding             w_coding;

    assign w_width_raw  = i_data[F_WIDTH_LSB +: COL_W];
    assign w_coding_raw = i_data[F_CODING_LSB +: CODING_W];

    // The fourth coding value decodes like two-bit run counts.
    always_comb begin
        unique case (t_coding'(w_coding_raw))
            COD_RAW:    w_coding = COD_RAW;
            COD_NIBBLE: w_coding = COD_NIBBLE;
            default:    w_coding = COD_PAIR;
        endcase
    end

    always_comb begin
        o_cmd.kind         = t_cmd_kind'(i_kind);
        o_cmd.width        = (w_width_raw > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : w_width_raw;
        o_cmd.left         = i_data[F_LEFT_LSB +: COL_W];
        o_cmd.right        = i_data[F_RIGHT_LSB +: COL_W];
        o_cmd.first_stripe = i_data[F_FIRST_LSB +: STRIPE_W];
        o_cmd.end_stripe   = i_data[F_END_LSB +: STRIPE_W];
        o_cmd.coding       = w_coding;
        o_cmd.data         = i_data[F_BYTE_LSB +: BYTE_W];
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

// File: src/gsrd_queue.sv
module gsrd_queue
    import gsrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_Q-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_Q-1:0] n_count;

    assign o_full  = (r_count == CNT_Q'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: src/gsrd_back.sv
module gsrd_back
    import gsrd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [STRIPE_W-1:0] i_n_stripes,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    output t_col                o_col,
    output logic                o_last,
    input  logic                i_ready
);

    t_state              r_state, n_state;
    logic                r_active, n_active;
    logic [STRIPE_W-1:0] r_stripe, n_stripe;
    logic [COL_W-1:0]    r_col, n_col;
    logic [BYTE_W-1:0]   r_run, n_run;
    logic                r_expect, n_expect;
    logic                r_ovr, n_ovr;
    logic [COL_W-1:0]    r_width, n_width;
    logic [COL_W-1:0]    r_left, n_left;
    logic [COL_W-1:0]    r_right, n_right;
    logic [STRIPE_W-1:0] r_first, n_first;
    logic [STRIPE_W-1:0] r_end_stripe, n_end_stripe;
    t_coding             r_coding, n_coding;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_hold_valid;
    t_col                r_hold;
    logic                r_out_valid;
    t_col                r_out;
    logic                r_out_last;

    logic              w_data_stripe;
    logic              w_past_width;
    logic              w_in_margin;
    logic              w_stripes_done;
    logic              w_wait_run;
    logic [CNT_W-1:0]  w_run_count;
    logic [BYTE_W-1:0] w_run_shifted;
    logic              w_run_step;
    logic              w_adv_emit;
    logic              w_adv_next;
    logic              w_adv_finish;
    logic              w_pop;
    logic              w_is_raw_put;
    logic              w_emit;
    logic              w_finish;
    logic              w_out_free;
    logic              w_stall;
    logic [BYTE_W-1:0] w_pix;
    t_col              w_col;

    assign w_data_stripe  = (r_stripe >= r_first) && (r_stripe < r_end_stripe);
    assign w_past_width   = (r_col >= r_width);
    assign w_in_margin    = (r_col < r_left)
                          || (({1'b0, r_col} + {1'b0, r_right}) >= {1'b0, r_width});
    assign w_stripes_done = (r_stripe >= i_n_stripes);
    assign w_wait_run     = w_data_stripe && (r_coding != COD_RAW) && !r_expect;

    assign w_run_count   = (r_coding == COD_NIBBLE) ? CNT_W'(r_run & RUN_MASK_NIBBLE)
                                                    : CNT_W'(r_run & RUN_MASK_PAIR);
    assign w_run_shifted = (r_coding == COD_NIBBLE) ? (r_run >> RUN_SHIFT_NIBBLE)
                                                    : (r_run >> RUN_SHIFT_PAIR);

    assign w_run_step = (r_cnt != '0) && !w_past_width;

    // One step of the blank-column walk, tested in priority order.
    assign w_adv_finish = !r_active || w_stripes_done || w_wait_run
                        || (!w_past_width && w_data_stripe && !w_in_margin);
    assign w_adv_next   = !w_adv_finish && w_past_width;
    assign w_adv_emit   = !w_adv_finish && !w_past_width;

    assign w_pop        = (r_state == S_IDLE) && i_cmd_valid;
    assign w_is_raw_put = w_pop && (i_cmd.kind == CMD_DATA) && r_active
                        && (r_coding == COD_RAW);

    always_comb begin
        w_emit   = 1'b0;
        w_finish = 1'b0;
        w_pix    = BLANK_PIXELS;
        unique case (r_state)
            S_IDLE: begin
                w_emit   = w_is_raw_put && !w_past_width;
                w_finish = w_pop && (i_cmd.kind == CMD_DATA) && !r_active;
                w_pix    = i_cmd.data;
            end
            S_RUN: begin
                w_emit = w_run_step;
                w_pix  = r_byte;
            end
            S_ADV: begin
                w_emit   = w_adv_emit;
                w_finish = w_adv_finish;
            end
            default: begin
                w_emit   = 1'b0;
                w_finish = 1'b0;
            end
        endcase
    end

    // A produced column waits in the hold stage until the next one shows
    // whether it is the last of its request.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_stall    = r_hold_valid && (w_emit || w_finish) && !w_out_free;

    always_comb begin
        w_col.stripe       = r_stripe[1:0];
        w_col.column       = r_col[3:0];
        w_col.pixels       = w_pix;
        w_col.stripe_start = (r_col == '0);
        w_col.glyph_done   = (({1'b0, r_col} + 1'b1) == {1'b0, r_width})
                           && (({1'b0, r_stripe} + 1'b1) == {1'b0, i_n_stripes});
        w_col.overrun      = r_ovr;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    if (i_cmd.kind == CMD_HEADER) begin
                        n_state = S_ADV;
                    end else if (!r_active) begin
                        n_state = S_IDLE;
                    end else if ((r_coding == COD_RAW) || r_expect) begin
                        n_state = S_ADV;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (!w_run_step) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                if (!w_stall && w_adv_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_active     = r_active;
        n_stripe     = r_stripe;
        n_col        = r_col;
        n_run        = r_run;
        n_expect     = r_expect;
        n_ovr        = r_ovr;
        n_width      = r_width;
        n_left       = r_left;
        n_right      = r_right;
        n_first      = r_first;
        n_end_stripe = r_end_stripe;
        n_coding     = r_coding;
        n_byte       = r_byte;
        n_cnt        = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop && (i_cmd.kind == CMD_HEADER)) begin
                    n_width      = i_cmd.width;
                    n_left       = i_cmd.left;
                    n_right      = i_cmd.right;
                    n_first      = i_cmd.first_stripe;
                    n_end_stripe = i_cmd.end_stripe;
                    n_coding     = i_cmd.coding;
                    n_ovr        = 1'b0;
                    n_stripe     = '0;
                    n_col        = '0;
                    n_run        = '0;
                    n_expect     = 1'b1;
                    n_active     = 1'b1;
                end else if (w_is_raw_put) begin
                    if (w_past_width) begin
                        n_ovr = 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else if (w_pop && r_active && r_expect) begin
                    n_run    = i_cmd.data;
                    n_expect = (i_cmd.data == '0);
                end else if (w_pop && r_active) begin
                    // Take the next chunk of the run byte as a repeat count.
                    n_cnt    = w_run_count;
                    n_byte   = i_cmd.data;
                    n_run    = w_run_shifted;
                    n_expect = (w_run_shifted == '0);
                    if (({1'b0, r_col} + (COL_W + 1)'(w_run_count)) > {1'b0, r_width}) begin
                        n_ovr = 1'b1;
                    end
                end
            end
            S_RUN: begin
                if (w_run_step && !w_stall) begin
                    n_col = r_col + 1'b1;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ADV: begin
                if (!w_stall) begin
                    if (r_active && w_stripes_done) begin
                        n_active = 1'b0;
                    end else if (w_adv_next) begin
                        n_stripe = r_stripe + 1'b1;
                        n_col    = '0;
                        n_run    = '0;
                        n_expect = 1'b1;
                    end else if (w_adv_emit) begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= 1'b0;
            r_stripe     <= '0;
            r_col        <= '0;
            r_run        <= '0;
            r_expect     <= 1'b1;
            r_ovr        <= 1'b0;
            r_width      <= '0;
            r_left       <= '0;
            r_right      <= '0;
            r_first      <= '0;
            r_end_stripe <= '0;
            r_coding     <= COD_RAW;
            r_cnt        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_stripe     <= n_stripe;
            r_col        <= n_col;
            r_run        <= n_run;
            r_expect     <= n_expect;
            r_ovr        <= n_ovr;
            r_width      <= n_width;
            r_left       <= n_left;
            r_right      <= n_right;
            r_first      <= n_first;
            r_end_stripe <= n_end_stripe;
            r_coding     <= n_coding;
            r_cnt        <= n_cnt;
            if (!w_stall) begin
                if (w_emit) begin
                    r_hold_valid <= 1'b1;
                end else if (w_finish) begin
                    r_hold_valid <= 1'b0;
                end
            end
            if (r_hold_valid && (w_emit || w_finish) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (!w_stall && w_emit) begin
            r_hold <= w_col;
        end
        if (r_hold_valid && (w_emit || w_finish) && w_out_free) begin
            r_out      <= r_hold;
            r_out_last <= w_finish;
        end
    end

    assign o_pop   = w_pop;
    assign o_valid = r_out_valid;
    assign o_col   = r_out;
    assign o_last  = r_out_last;

endmodule

// File: src/glyph_stripe_rle_decoder.sv
// Glyph stripe decoder: takes a header request and then the compressed bytes of one glyph
// and returns the glyph as 8-pixel column bytes, stripe by stripe, with blank
// margins and empty stripes filled in. Requests pass through a two-entry queue
// to a back end that produces at most one column per cycle. A request is issued
// in the idle state, a run chunk then yields its columns in the run state, and
// the advance state fills in blank columns and stripe changes and closes the
// request; a raw data byte yields its column in the idle state, and a data byte
// with no glyph in progress ends there. A stalled output holds the back end,
// whose single column path sets this rate. tlast marks the final column caused
// by one request; a request that yields no column gives no output. The stripe
// count register may be written only while no request is in flight.
module glyph_stripe_rle_decoder
    import gsrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // glyph_width, left_blank, right_blank, first_stripe, end_stripe, coding, byte_in
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // command
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // stripe_index, column, pixels, stripe_start, glyph_done, overrun
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    input  logic                 i_cfg_wr_en,
    input  logic [STRIPE_W-1:0]  i_cfg_wr_data
);

    logic [STRIPE_W-1:0] r_stripe_count;
    logic [STRIPE_W-1:0] w_n_stripes;
    logic                w_queue_full;
    logic                w_push;
    t_cmd                w_front_cmd;
    logic                w_pop;
    logic                w_cmd_valid;
    t_cmd                w_queue_cmd;
    t_col                w_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stripe_count <= STRIPE_W'(1);
        end else if (i_cfg_wr_en) begin
            r_stripe_count <= i_cfg_wr_data;
        end
    end

    assign w_n_stripes = (r_stripe_count > STRIPE_W'(MAX_STRIPES)) ? STRIPE_W'(MAX_STRIPES)
                                                                  : r_stripe_count;

    gsrd_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_data       (i_s_axis_tdata),
        .i_kind       (i_s_axis_tuser),
        .i_queue_full (w_queue_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    gsrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_queue_cmd)
    );

    gsrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_stripes (w_n_stripes),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .o_col       (w_col),
        .o_last      (o_m_axis_tlast),
        .i_ready     (i_m_axis_tready)
    );

    assign o_m_axis_tdata = M_TDATA_W'(w_col);

endmodule

// File: src/gsrd_checker.sv
`include "glyph_stripe_rle_decoder_macros.svh"

module gsrd_checker
    import gsrd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tlast
);

    // Bit 14 is stripe_start, bit 15 glyph_done, bits 5:2 the column.

    `GSRD_ASSERT(a_valid_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "output request dropped while stalled")

    `GSRD_ASSERT(a_payload_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output payload changed while stalled")

    `GSRD_ASSERT(a_done_is_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[15] |-> o_m_axis_tlast, "final glyph column not marked last")

    `GSRD_ASSERT(a_start_col_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[14] |-> o_m_axis_tdata[5:2] == 4'd0, "stripe start away from column zero")

    `GSRD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind glyph_stripe_rle_decoder gsrd_checker u_checker (.*);
